// ===== hw/rtl/tsmlfo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tempo-synced multiwave LFO package
// Shared widths, fixed-point constants, codes and a saturating helper function.
// ----------------------------------------------------------------------------
package tsmlfo_pkg;

    localparam int FRAC_BITS         = 24;
    localparam int VW                = FRAC_BITS + 3;
    localparam int OW                = 24;
    localparam int OUT_SHIFT         = FRAC_BITS - 22;
    localparam int OUT_MAX           = 8388607;
    localparam int OUT_MIN           = -8388608;
    localparam int LANES             = 5;
    localparam int BASE_W            = 23;
    localparam int STEP_SHW          = BASE_W + 8;
    localparam int LFSR_W            = 32;
    localparam int CFG_W             = 32;
    localparam int CTRL_INTERVAL_DEF = 16;

    localparam int LANE_SINE = 0;
    localparam int LANE_SAW  = 1;
    localparam int LANE_TRI  = 2;
    localparam int LANE_RECT = 3;
    localparam int LANE_SH   = 4;

    typedef logic signed [VW-1:0]   t_val;
    typedef logic signed [VW:0]     t_wide;
    typedef logic signed [2*VW:0]   t_big;
    typedef logic signed [1:0]      t_level;
    typedef logic [FRAC_BITS:0]     t_step;

    localparam t_val  ONE      = t_val'(longint'(1) << FRAC_BITS);
    localparam t_val  VLIM     = t_val'((longint'(1) << (FRAC_BITS + 2)) - 1);
    localparam t_wide TWO_W    = t_wide'(longint'(2) << FRAC_BITS);
    localparam t_step STEP_MAX = t_step'(longint'(1) << FRAC_BITS);

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [LFSR_W-1:0] LFSR_ONE  = 32'h0000_0001;

    localparam t_level LVL_LOW  = 2'sb11;
    localparam t_level LVL_ZERO = 2'sb00;
    localparam t_level LVL_HIGH = 2'sb01;

    typedef enum logic [1:0] {
        REG_WAVE,
        REG_STEP,
        REG_SHIFT,
        REG_SEED
    } t_reg_idx;

    typedef enum logic [2:0] {
        WAVE_SINE,
        WAVE_TRI,
        WAVE_SAW_UP,
        WAVE_SAW_DOWN,
        WAVE_RECT,
        WAVE_SH
    } t_wave;

    typedef enum logic [1:0] {
        QTR_UP_POS,
        QTR_DOWN_POS,
        QTR_DOWN_NEG,
        QTR_UP_NEG
    } t_quarter;

    function automatic t_val sat_val(input t_big v);
        t_val r;
        if (v > t_big'(VLIM)) begin
            r = VLIM;
        end else if (v < -t_big'(VLIM)) begin
            r = -VLIM;
        end else begin
            r = t_val'(v);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/tempo_synced_multiwave_lfo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tempo-synced multiwave LFO
// One LFO sample per audio frame, with control points every CTRL_INTERVAL
// frames and linear interpolation between them.
// ----------------------------------------------------------------------------
// Channel      Direction  Payload                          Handshake
// s_axis       in         tdata[0] reset_gate              tvalid/tready
// m_axis       out        tdata[23:0] lfo_sample (signed)  tvalid/tready
// cfg          in         index/wdata                      i_cfg_we, no wait
//
// One request per clock is taken while m_axis does not stall; each sample passes
// through the six-stage pipeline (state update, sine product, target difference,
// reciprocal multiply, interpolation).
// Synchronous active-low reset empties the pipeline and clears all but its payload.
// A stall on m_axis fills empty stages first, then holds s_axis_tready low.
// ----------------------------------------------------------------------------
module tempo_synced_multiwave_lfo #(
    parameter int CTRL_INTERVAL = tsmlfo_pkg::CTRL_INTERVAL_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [tsmlfo_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [0] reset_gate
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic signed [23:0]          m_axis_tdata    // [23:0] lfo_sample
);

    localparam int VW        = tsmlfo_pkg::VW;
    localparam int LANES     = tsmlfo_pkg::LANES;
    localparam int CW        = $clog2(CTRL_INTERVAL);
    localparam int DIV_SHIFT = VW + $clog2(CTRL_INTERVAL);
    localparam int MW        = VW + 2;
    localparam int PW        = VW + MW;
    localparam int QW        = VW - 1;
    localparam logic [MW-1:0] RECIP = MW'(((longint'(1) << DIV_SHIFT)
        + longint'(CTRL_INTERVAL) - 1) / longint'(CTRL_INTERVAL));
    localparam tsmlfo_pkg::t_val N_V = tsmlfo_pkg::t_val'(CTRL_INTERVAL);
    localparam logic [CW-1:0] LAST_FRAME = CW'(CTRL_INTERVAL - 1);

    // Configuration.
    logic [2:0]                    r_wave;
    logic [tsmlfo_pkg::BASE_W-1:0] r_base;
    logic signed [3:0]             r_mshift;

    // Control-point state.
    tsmlfo_pkg::t_val        r_phase;
    tsmlfo_pkg::t_quarter    r_quarter;
    logic                    r_latched;
    tsmlfo_pkg::t_val        r_saw;
    tsmlfo_pkg::t_level      r_square;
    tsmlfo_pkg::t_val        r_held;
    logic [tsmlfo_pkg::LFSR_W-1:0] r_lfsr;
    logic [CW-1:0]           r_frame;

    // Interpolators.
    tsmlfo_pkg::t_val r_pos   [LANES];
    tsmlfo_pkg::t_val r_slope [LANES];
    tsmlfo_pkg::t_val r_p     [LANES];

    // Pipeline stages.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic r_cp1, r_cp2, r_cp3, r_cp4, r_cp5;
    logic r_gate1;
    tsmlfo_pkg::t_val   r_a2;
    tsmlfo_pkg::t_wide  r_b2;
    tsmlfo_pkg::t_val   r_saw2, r_tri2, r_sh2;
    tsmlfo_pkg::t_level r_rect2;
    tsmlfo_pkg::t_big   r_prod3;
    tsmlfo_pkg::t_val   r_saw3, r_tri3, r_sh3;
    tsmlfo_pkg::t_level r_rect3;
    tsmlfo_pkg::t_wide  r_diff4 [LANES];
    logic [QW-1:0]      r_q5    [LANES];
    logic               r_neg5  [LANES];
    logic signed [tsmlfo_pkg::OW-1:0] r_out6;

    logic adv1, adv2, adv3, adv4, adv5, adv6;
    logic accept;

    // Stage 1 to 2 signals.
    logic [tsmlfo_pkg::STEP_SHW-1:0] step_ext;
    logic [tsmlfo_pkg::STEP_SHW-1:0] step_sh;
    logic [3:0]                      neg_sh;
    tsmlfo_pkg::t_step               dt0;
    logic                            rise;
    logic                            draw;
    logic                            down;
    tsmlfo_pkg::t_val                ph0;
    tsmlfo_pkg::t_quarter            q0;
    tsmlfo_pkg::t_level              sq0;
    tsmlfo_pkg::t_val                saw0;
    logic [tsmlfo_pkg::LFSR_W-1:0]   lfsr_step;
    tsmlfo_pkg::t_val                rnd;
    tsmlfo_pkg::t_quarter            n_quarter;
    tsmlfo_pkg::t_level              n_square;
    tsmlfo_pkg::t_val                n_saw;
    tsmlfo_pkg::t_val                n_phase;
    tsmlfo_pkg::t_val                n_held;
    logic [tsmlfo_pkg::LFSR_W-1:0]   n_lfsr;
    tsmlfo_pkg::t_wide               b_val;

    // Stage 3 to 6 signals.
    tsmlfo_pkg::t_val  tgt     [LANES];
    tsmlfo_pkg::t_val  p_eff   [LANES];
    tsmlfo_pkg::t_val  s5      [LANES];
    tsmlfo_pkg::t_val  pos_new [LANES];
    logic [VW-1:0]     mag     [LANES];
    logic [PW-1:0]     quot_pr [LANES];
    tsmlfo_pkg::t_val  sel;
    tsmlfo_pkg::t_val  sel_sh;
    logic signed [tsmlfo_pkg::OW-1:0] out_val;

    assign adv6 = !r_v6 || m_axis_tready;
    assign adv5 = !r_v5 || adv6;
    assign adv4 = !r_v4 || adv5;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign s_axis_tready = adv1;
    assign accept = s_axis_tvalid && adv1;
    assign m_axis_tvalid = r_v6;
    assign m_axis_tdata  = r_out6;

    // Tempo-scaled phase step, saturated at 1.0.
    always_comb begin
        step_ext = {8'b0, r_base};
        neg_sh   = 4'(-r_mshift);
        if (!r_mshift[3]) begin
            step_sh = step_ext << r_mshift[2:0];
        end else begin
            step_sh = step_ext >> neg_sh;
        end
        if (step_sh > tsmlfo_pkg::STEP_SHW'(tsmlfo_pkg::STEP_MAX)) begin
            dt0 = tsmlfo_pkg::STEP_MAX;
        end else begin
            dt0 = tsmlfo_pkg::t_step'(step_sh);
        end
    end

    // Control point: gate edge, quarter sequencing and new targets.
    always_comb begin
        rise = !r_latched && r_gate1;
        ph0  = rise ? '0 : r_phase;
        q0   = rise ? tsmlfo_pkg::QTR_UP_POS : r_quarter;
        sq0  = rise ? tsmlfo_pkg::LVL_LOW : r_square;
        saw0 = rise ? '0 : r_saw;

        lfsr_step = {1'b0, r_lfsr[tsmlfo_pkg::LFSR_W-1:1]}
            ^ (r_lfsr[0] ? tsmlfo_pkg::LFSR_TAPS : '0);
        rnd = tsmlfo_pkg::t_val'(
            lfsr_step[tsmlfo_pkg::LFSR_W-1 -: tsmlfo_pkg::FRAC_BITS + 1])
            - tsmlfo_pkg::ONE;

        draw      = 1'b0;
        n_quarter = q0;
        n_square  = sq0;
        n_saw     = saw0;
        if (ph0 >= tsmlfo_pkg::ONE) begin
            n_quarter = tsmlfo_pkg::QTR_DOWN_POS;
        end else if (ph0 <= -tsmlfo_pkg::ONE) begin
            n_quarter = tsmlfo_pkg::QTR_UP_NEG;
        end else if (q0 == tsmlfo_pkg::QTR_DOWN_POS && ph0 < 0) begin
            n_quarter = tsmlfo_pkg::QTR_DOWN_NEG;
            n_square  = tsmlfo_pkg::LVL_HIGH;
            draw      = 1'b1;
        end else if (q0 == tsmlfo_pkg::QTR_UP_NEG && ph0 > 0) begin
            n_quarter = tsmlfo_pkg::QTR_UP_POS;
            n_square  = tsmlfo_pkg::LVL_LOW;
            draw      = 1'b1;
            n_saw     = -tsmlfo_pkg::ONE;
        end

        down = (n_quarter == tsmlfo_pkg::QTR_DOWN_POS)
            || (n_quarter == tsmlfo_pkg::QTR_DOWN_NEG);
        if (down) begin
            b_val = tsmlfo_pkg::TWO_W + tsmlfo_pkg::t_wide'(ph0);
            n_phase = tsmlfo_pkg::sat_val(tsmlfo_pkg::t_big'(
                tsmlfo_pkg::t_wide'(ph0) - tsmlfo_pkg::t_wide'(dt0)));
        end else begin
            b_val = tsmlfo_pkg::TWO_W - tsmlfo_pkg::t_wide'(ph0);
            n_phase = tsmlfo_pkg::sat_val(tsmlfo_pkg::t_big'(
                tsmlfo_pkg::t_wide'(ph0) + tsmlfo_pkg::t_wide'(dt0)));
        end
        if (n_quarter == tsmlfo_pkg::QTR_DOWN_NEG) begin
            b_val = tsmlfo_pkg::TWO_W + tsmlfo_pkg::t_wide'(ph0);
        end else if (n_quarter == tsmlfo_pkg::QTR_UP_NEG) begin
            b_val = tsmlfo_pkg::TWO_W + tsmlfo_pkg::t_wide'(ph0);
        end else begin
            b_val = tsmlfo_pkg::TWO_W - tsmlfo_pkg::t_wide'(ph0);
        end
        n_saw = tsmlfo_pkg::sat_val(tsmlfo_pkg::t_big'(
            tsmlfo_pkg::t_wide'(n_saw) + tsmlfo_pkg::t_wide'(dt0 >> 1)));
        n_held = draw ? rnd : r_held;
        n_lfsr = draw ? lfsr_step : r_lfsr;
    end

    // The position at each control point is tracked exactly, so the slope of
    // the next interval can be formed before the interpolators reach it.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            s5[i] = r_neg5[i] ? -tsmlfo_pkg::t_val'(r_q5[i])
                              : tsmlfo_pkg::t_val'(r_q5[i]);
            p_eff[i] = (r_v5 && r_cp5) ? r_p[i] + s5[i] * N_V : r_p[i];
            pos_new[i] = r_cp5 ? r_pos[i] + s5[i] : r_pos[i] + r_slope[i];
            mag[i] = VW'(r_diff4[i] < 0 ? -r_diff4[i] : r_diff4[i]);
            quot_pr[i] = mag[i] * RECIP;
        end
        tgt[tsmlfo_pkg::LANE_SINE] =
            tsmlfo_pkg::sat_val(r_prod3 >>> tsmlfo_pkg::FRAC_BITS);
        tgt[tsmlfo_pkg::LANE_SAW] = r_saw3;
        tgt[tsmlfo_pkg::LANE_TRI] = r_tri3;
        if (r_rect3 == tsmlfo_pkg::LVL_HIGH) begin
            tgt[tsmlfo_pkg::LANE_RECT] = tsmlfo_pkg::ONE;
        end else if (r_rect3 == tsmlfo_pkg::LVL_LOW) begin
            tgt[tsmlfo_pkg::LANE_RECT] = -tsmlfo_pkg::ONE;
        end else begin
            tgt[tsmlfo_pkg::LANE_RECT] = '0;
        end
        tgt[tsmlfo_pkg::LANE_SH] = r_sh3;
    end

    always_comb begin
        case (r_wave)
            tsmlfo_pkg::WAVE_SINE:     sel = pos_new[tsmlfo_pkg::LANE_SINE];
            tsmlfo_pkg::WAVE_TRI:      sel = pos_new[tsmlfo_pkg::LANE_TRI];
            tsmlfo_pkg::WAVE_SAW_UP:   sel = pos_new[tsmlfo_pkg::LANE_SAW];
            tsmlfo_pkg::WAVE_SAW_DOWN: sel = -pos_new[tsmlfo_pkg::LANE_SAW];
            tsmlfo_pkg::WAVE_RECT:     sel = -pos_new[tsmlfo_pkg::LANE_RECT];
            tsmlfo_pkg::WAVE_SH:       sel = pos_new[tsmlfo_pkg::LANE_SH];
            default:                   sel = '0;
        endcase
        sel_sh = sel >>> tsmlfo_pkg::OUT_SHIFT;
        if (sel_sh > tsmlfo_pkg::t_val'(tsmlfo_pkg::OUT_MAX)) begin
            out_val = tsmlfo_pkg::OW'(tsmlfo_pkg::OUT_MAX);
        end else if (sel_sh < tsmlfo_pkg::t_val'(tsmlfo_pkg::OUT_MIN)) begin
            out_val = tsmlfo_pkg::OW'(tsmlfo_pkg::OUT_MIN);
        end else begin
            out_val = tsmlfo_pkg::OW'(sel_sh);
        end
    end

    // Valids, configuration and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_v6      <= 1'b0;
            r_frame   <= '0;
            r_wave    <= 3'(tsmlfo_pkg::WAVE_SINE);
            r_base    <= tsmlfo_pkg::BASE_W'(44739);
            r_mshift  <= '0;
            r_lfsr    <= tsmlfo_pkg::LFSR_ONE;
            r_phase   <= '0;
            r_quarter <= tsmlfo_pkg::QTR_UP_POS;
            r_latched <= 1'b0;
            r_saw     <= -tsmlfo_pkg::ONE;
            r_square  <= tsmlfo_pkg::LVL_ZERO;
            r_held    <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_pos[i]   <= '0;
                r_slope[i] <= '0;
                r_p[i]     <= '0;
            end
        end else begin
            if (adv1) r_v1 <= s_axis_tvalid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
            if (adv5) r_v5 <= r_v4;
            if (adv6) r_v6 <= r_v5;

            if (accept) begin
                r_frame <= (r_frame == LAST_FRAME) ? '0 : r_frame + 1'b1;
            end

            if (adv2 && r_v1 && r_cp1) begin
                r_phase   <= n_phase;
                r_quarter <= n_quarter;
                r_latched <= r_gate1;
                r_saw     <= n_saw;
                r_square  <= n_square;
                r_held    <= n_held;
                r_lfsr    <= n_lfsr;
            end

            if (adv6 && r_v5) begin
                for (int i = 0; i < LANES; i++) begin
                    r_pos[i] <= pos_new[i];
                    if (r_cp5) begin
                        r_slope[i] <= s5[i];
                        r_p[i]     <= r_p[i] + s5[i] * N_V;
                    end
                end
            end

            if (i_cfg_we) begin
                unique case (tsmlfo_pkg::t_reg_idx'(i_cfg_index))
                    tsmlfo_pkg::REG_WAVE:  r_wave   <= i_cfg_wdata[2:0];
                    tsmlfo_pkg::REG_STEP:  r_base   <= i_cfg_wdata[tsmlfo_pkg::BASE_W-1:0];
                    tsmlfo_pkg::REG_SHIFT: r_mshift <= i_cfg_wdata[3:0];
                    tsmlfo_pkg::REG_SEED: begin
                        r_lfsr <= (i_cfg_wdata == '0) ? tsmlfo_pkg::LFSR_ONE
                                                      : i_cfg_wdata;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_gate1 <= s_axis_tdata[0];
            r_cp1   <= (r_frame == '0);
        end
        if (adv2 && r_v1) begin
            r_cp2   <= r_cp1;
            r_a2    <= ph0;
            r_b2    <= b_val;
            r_saw2  <= n_saw;
            r_tri2  <= n_phase;
            r_rect2 <= n_square;
            r_sh2   <= n_held;
        end
        if (adv3 && r_v2) begin
            r_cp3   <= r_cp2;
            r_prod3 <= r_a2 * r_b2;
            r_saw3  <= r_saw2;
            r_tri3  <= r_tri2;
            r_rect3 <= r_rect2;
            r_sh3   <= r_sh2;
        end
        if (adv4 && r_v3) begin
            r_cp4 <= r_cp3;
            for (int i = 0; i < LANES; i++) begin
                r_diff4[i] <= tsmlfo_pkg::t_wide'(tgt[i])
                    - tsmlfo_pkg::t_wide'(p_eff[i]);
            end
        end
        if (adv5 && r_v4) begin
            r_cp5 <= r_cp4;
            for (int i = 0; i < LANES; i++) begin
                r_q5[i]   <= QW'(quot_pr[i] >> DIV_SHIFT);
                r_neg5[i] <= r_diff4[i] < 0;
            end
        end
        if (adv6 && r_v5) begin
            r_out6 <= out_val;
        end
    end

endmodule
